// ----- src/nectx_pkg.sv -----
// Shared types, register codes and reset values of the NEC infrared frame transmitter.
package nectx_pkg;

  // Field widths
  localparam int unsigned CarrierW = 8;
  localparam int unsigned LenW     = 14;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 14;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned WordW    = 32;

  // Default number of data bits in a frame
  localparam int unsigned FrameBitsDef = 32;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegCarrierHalf = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHeaderMark  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHeaderSpace = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBitMark     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegZeroSpace   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegOneSpace    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegStopLen     = 3'd6;

  // Reset values of the registers
  localparam logic [CarrierW-1:0] CarrierHalfRst = 8'd12;
  localparam logic [LenW-1:0]     HeaderMarkRst  = 14'd8295;
  localparam logic [LenW-1:0]     HeaderSpaceRst = 14'd4146;
  localparam logic [LenW-1:0]     BitMarkRst     = 14'd521;
  localparam logic [LenW-1:0]     ZeroSpaceRst   = 14'd521;
  localparam logic [LenW-1:0]     OneSpaceRst    = 14'd1563;
  localparam logic [LenW-1:0]     StopLenRst     = 14'd500;

  // Frame sequencer phases
  typedef enum logic [2:0] {
    PhIdle   = 3'd0,
    PhHMark  = 3'd1,
    PhHSpace = 3'd2,
    PhBMark  = 3'd3,
    PhBSpace = 3'd4,
    PhSMark  = 3'd5,
    PhSSpace = 3'd6
  } phase_e;

  // Timing registers as seen by the sequencer
  typedef struct packed {
    logic [CarrierW-1:0] carrier_half;
    logic [LenW-1:0]     header_mark;
    logic [LenW-1:0]     header_space;
    logic [LenW-1:0]     bit_mark;
    logic [LenW-1:0]     zero_space;
    logic [LenW-1:0]     one_space;
    logic [LenW-1:0]     stop_len;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic ir_level;
    logic busy;
    logic frame_end;
  } res_t;

endpackage

// ----- src/nectx_seq.sv -----
// Frame sequencer: phase, bit counter, shift register, segment and carrier timers.
module nectx_seq #(
  parameter int unsigned FRAME_BITS = nectx_pkg::FrameBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          mode_i,
  input  logic [nectx_pkg::ByteW-1:0]   address_i,
  input  logic [nectx_pkg::ByteW-1:0]   payload_i,
  input  nectx_pkg::cfg_t               cfg_i,
  output nectx_pkg::res_t               res_o
);

  localparam int unsigned BitCntW = $clog2(FRAME_BITS + 1);
  localparam int unsigned CarrW   = nectx_pkg::CarrierW;
  localparam int unsigned LenW    = nectx_pkg::LenW;

  nectx_pkg::phase_e       phase_q, phase_d;
  logic [BitCntW-1:0]      bits_q, bits_d;
  logic [FRAME_BITS-1:0]   shift_q, shift_d;
  logic [LenW-1:0]         seg_q, seg_d;
  logic [CarrW-1:0]        carr_q, carr_d;
  logic                    level_q, level_d;
  logic                    mark_q, mark_d;

  logic [nectx_pkg::WordW-1:0] frame_word;
  logic [LenW-1:0]             seg_len;
  logic [LenW-1:0]             seg_inc;
  logic [CarrW:0]              carr_inc;
  logic [BitCntW-1:0]          bits_inc;
  logic                        fend;

  // Frame word, sent LSB first
  assign frame_word = {~payload_i, payload_i, ~address_i, address_i};
  assign seg_inc    = seg_q + LenW'(1);
  assign carr_inc   = {1'b0, carr_q} + (CarrW+1)'(1);
  assign bits_inc   = bits_q + BitCntW'(1);

  // Length of the current segment
  always_comb begin
    case (phase_q)
      nectx_pkg::PhHMark:  seg_len = cfg_i.header_mark;
      nectx_pkg::PhHSpace: seg_len = cfg_i.header_space;
      nectx_pkg::PhBMark:  seg_len = cfg_i.bit_mark;
      nectx_pkg::PhBSpace: seg_len = shift_q[0] ? cfg_i.one_space : cfg_i.zero_space;
      default:             seg_len = cfg_i.stop_len;
    endcase
  end

  // Next state for one item
  always_comb begin
    phase_d = phase_q;
    bits_d  = bits_q;
    shift_d = shift_q;
    seg_d   = seg_q;
    carr_d  = carr_q;
    level_d = level_q;
    mark_d  = mark_q;
    fend    = 1'b0;
    if (step_i) begin
      if (mode_i) begin
        if (phase_q == nectx_pkg::PhIdle) begin
          shift_d = frame_word[FRAME_BITS-1:0];
          bits_d  = '0;
          phase_d = nectx_pkg::PhHMark;
          mark_d  = 1'b1;
          seg_d   = '0;
          carr_d  = '0;
          level_d = 1'b1;
        end
      end else if (phase_q != nectx_pkg::PhIdle) begin
        // carrier toggling inside a mark
        if (mark_q) begin
          if (carr_inc >= {1'b0, cfg_i.carrier_half}) begin
            level_d = ~level_q;
            carr_d  = '0;
          end else begin
            carr_d  = carr_inc[CarrW-1:0];
          end
        end
        seg_d = seg_inc;
        // segment end: move on with line high and timers cleared
        if (seg_inc >= seg_len) begin
          seg_d   = '0;
          carr_d  = '0;
          level_d = 1'b1;
          case (phase_q)
            nectx_pkg::PhHMark: begin
              phase_d = nectx_pkg::PhHSpace;
              mark_d  = 1'b0;
            end
            nectx_pkg::PhHSpace: begin
              phase_d = nectx_pkg::PhBMark;
              mark_d  = 1'b1;
            end
            nectx_pkg::PhBMark: begin
              phase_d = nectx_pkg::PhBSpace;
              mark_d  = 1'b0;
            end
            nectx_pkg::PhBSpace: begin
              shift_d = shift_q >> 1;
              bits_d  = bits_inc;
              mark_d  = 1'b1;
              if (bits_inc >= BitCntW'(FRAME_BITS)) begin
                phase_d = nectx_pkg::PhSMark;
              end else begin
                phase_d = nectx_pkg::PhBMark;
              end
            end
            nectx_pkg::PhSMark: begin
              phase_d = nectx_pkg::PhSSpace;
              mark_d  = 1'b0;
            end
            default: begin
              phase_d = nectx_pkg::PhIdle;
              mark_d  = 1'b0;
              fend    = 1'b1;
            end
          endcase
        end
      end
    end
  end

  // Result of the item just applied
  always_comb begin
    res_o.ir_level  = level_d;
    res_o.busy      = (phase_d != nectx_pkg::PhIdle);
    res_o.frame_end = fend;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nectx_pkg::PhIdle;
      bits_q  <= '0;
      shift_q <= '0;
      seg_q   <= '0;
      carr_q  <= '0;
      level_q <= 1'b1;
      mark_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      bits_q  <= bits_d;
      shift_q <= shift_d;
      seg_q   <= seg_d;
      carr_q  <= carr_d;
      level_q <= level_d;
      mark_q  <= mark_d;
    end
  end

endmodule

// ----- src/nec_ir_frame_transmitter.sv -----
// Top level of the NEC infrared frame transmitter: registers, handshake and result register.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    mode_i, address_i, payload_i
//   out      output     out_valid_o / out_ready_i  ir_level_o, busy_res_o, frame_end_o
//   cfg      input      cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// One item per clock while the out side keeps up: each accepted item updates the sequencer
// state and the result register at the accepting edge, and its result is then on out_valid_o.
// in_ready_o is high while the result register is empty or being emptied, so a stall on
// the out side holds only one item back. Reset clears the state to idle with the line
// high and loads the default timing values.
module nec_ir_frame_transmitter #(
  parameter int unsigned FRAME_BITS = nectx_pkg::FrameBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nectx_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [nectx_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [nectx_pkg::ByteW-1:0]       address_i,
  input  logic [nectx_pkg::ByteW-1:0]       payload_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              ir_level_o,
  output logic                              busy_res_o,
  output logic                              frame_end_o
);

  nectx_pkg::cfg_t cfg_q;
  nectx_pkg::res_t res_d, res_q;
  logic            valid_q;
  logic            accept;

  assign in_ready_o = ~valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  // Timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.carrier_half <= nectx_pkg::CarrierHalfRst;
      cfg_q.header_mark  <= nectx_pkg::HeaderMarkRst;
      cfg_q.header_space <= nectx_pkg::HeaderSpaceRst;
      cfg_q.bit_mark     <= nectx_pkg::BitMarkRst;
      cfg_q.zero_space   <= nectx_pkg::ZeroSpaceRst;
      cfg_q.one_space    <= nectx_pkg::OneSpaceRst;
      cfg_q.stop_len     <= nectx_pkg::StopLenRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nectx_pkg::RegCarrierHalf: cfg_q.carrier_half <= cfg_data_i[nectx_pkg::CarrierW-1:0];
        nectx_pkg::RegHeaderMark:  cfg_q.header_mark  <= cfg_data_i;
        nectx_pkg::RegHeaderSpace: cfg_q.header_space <= cfg_data_i;
        nectx_pkg::RegBitMark:     cfg_q.bit_mark     <= cfg_data_i;
        nectx_pkg::RegZeroSpace:   cfg_q.zero_space   <= cfg_data_i;
        nectx_pkg::RegOneSpace:    cfg_q.one_space    <= cfg_data_i;
        nectx_pkg::RegStopLen:     cfg_q.stop_len     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame sequencer
  nectx_seq #(
    .FRAME_BITS (FRAME_BITS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (accept),
    .mode_i    (mode_i),
    .address_i (address_i),
    .payload_i (payload_i),
    .cfg_i     (cfg_q),
    .res_o     (res_d)
  );

  // Result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= accept;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign ir_level_o  = res_q.ir_level;
  assign busy_res_o  = res_q.busy;
  assign frame_end_o = res_q.frame_end;

endmodule

// ----- tb/sv/nec_ir_frame_transmitter_tb.sv -----
// Self-checking testbench for the NEC infrared frame transmitter: random handshakes, line checks.
module nec_ir_frame_transmitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Widths taken from the package
  localparam int unsigned CarrierW = nectx_pkg::CarrierW;
  localparam int unsigned LenW     = nectx_pkg::LenW;
  localparam int unsigned CfgIdxW  = nectx_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = nectx_pkg::CfgDataW;
  localparam int unsigned ByteW    = nectx_pkg::ByteW;
  localparam int unsigned WordW    = nectx_pkg::WordW;

  // Index that no register answers to
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int unsigned RandItems = 1000;
  localparam longint unsigned CycleLimit = 64'd20_000_000;

  // Tracks the transmitter state, predicts the line after each item and checks results
  class frame_tracker;
    nectx_pkg::cfg_t     regs;
    nectx_pkg::phase_e   phase;
    logic [5:0]          bits_sent;
    logic [WordW-1:0]    shift;
    logic [LenW-1:0]     seg_cnt;
    logic [CarrierW-1:0] car_cnt;
    logic                level;
    logic                in_mark;
    nectx_pkg::res_t     expected_line[$];
    int unsigned         mismatches;
    int unsigned         frames_done;
    int unsigned         ignored_sends;

    function new();
      regs = '{nectx_pkg::CarrierHalfRst, nectx_pkg::HeaderMarkRst,
               nectx_pkg::HeaderSpaceRst, nectx_pkg::BitMarkRst,
               nectx_pkg::ZeroSpaceRst, nectx_pkg::OneSpaceRst, nectx_pkg::StopLenRst};
      phase = nectx_pkg::PhIdle;
      bits_sent = '0;
      shift = '0;
      seg_cnt = '0;
      car_cnt = '0;
      level = 1'b1;
      in_mark = 1'b0;
      mismatches = 0;
      frames_done = 0;
      ignored_sends = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        nectx_pkg::RegCarrierHalf: regs.carrier_half = data[CarrierW-1:0];
        nectx_pkg::RegHeaderMark:  regs.header_mark  = data[LenW-1:0];
        nectx_pkg::RegHeaderSpace: regs.header_space = data[LenW-1:0];
        nectx_pkg::RegBitMark:     regs.bit_mark     = data[LenW-1:0];
        nectx_pkg::RegZeroSpace:   regs.zero_space   = data[LenW-1:0];
        nectx_pkg::RegOneSpace:    regs.one_space    = data[LenW-1:0];
        nectx_pkg::RegStopLen:     regs.stop_len     = data[LenW-1:0];
        default: ;
      endcase
    endfunction

    function bit busy();
      return phase != nectx_pkg::PhIdle;
    endfunction

    function int unsigned pending();
      return expected_line.size();
    endfunction

    // Length of the segment in progress; the space length follows the bit on the wire
    function logic [LenW-1:0] seg_span();
      case (phase)
        nectx_pkg::PhHMark:  return regs.header_mark;
        nectx_pkg::PhHSpace: return regs.header_space;
        nectx_pkg::PhBMark:  return regs.bit_mark;
        nectx_pkg::PhBSpace: return shift[0] ? regs.one_space : regs.zero_space;
        default:             return regs.stop_len;
      endcase
    endfunction

    function void enter(nectx_pkg::phase_e nxt, logic mark);
      phase = nxt;
      in_mark = mark;
      seg_cnt = '0;
      car_cnt = '0;
      level = 1'b1;
    endfunction

    // Apply one accepted item and queue the line it should produce
    function void log_item(logic mode, logic [ByteW-1:0] addr, logic [ByteW-1:0] pay);
      logic [LenW-1:0]   span;
      logic [CarrierW:0] car_next;
      logic              fend;
      nectx_pkg::res_t   r;
      fend = 1'b0;
      if (mode) begin
        if (phase == nectx_pkg::PhIdle) begin
          shift = {~pay, pay, ~addr, addr};
          bits_sent = '0;
          enter(nectx_pkg::PhHMark, 1'b1);
        end else begin
          ignored_sends++;
        end
      end else if (phase != nectx_pkg::PhIdle) begin
        span = seg_span();
        // carrier toggles while in a mark; a zero half period toggles every tick
        if (in_mark) begin
          car_next = {1'b0, car_cnt} + 1'b1;
          if (car_next >= {1'b0, regs.carrier_half}) begin
            level = ~level;
            car_cnt = '0;
          end else begin
            car_cnt = car_next[CarrierW-1:0];
          end
        end
        seg_cnt = seg_cnt + 1'b1;
        if (seg_cnt >= span) begin
          case (phase)
            nectx_pkg::PhHMark:  enter(nectx_pkg::PhHSpace, 1'b0);
            nectx_pkg::PhHSpace: enter(nectx_pkg::PhBMark, 1'b1);
            nectx_pkg::PhBMark:  enter(nectx_pkg::PhBSpace, 1'b0);
            nectx_pkg::PhBSpace: begin
              shift = shift >> 1;
              bits_sent = bits_sent + 1'b1;
              if (bits_sent >= nectx_pkg::FrameBitsDef) begin
                enter(nectx_pkg::PhSMark, 1'b1);
              end else begin
                enter(nectx_pkg::PhBMark, 1'b1);
              end
            end
            nectx_pkg::PhSMark:  enter(nectx_pkg::PhSSpace, 1'b0);
            default: begin
              enter(nectx_pkg::PhIdle, 1'b0);
              fend = 1'b1;
              frames_done++;
            end
          endcase
        end
      end
      r.ir_level = level;
      r.busy = (phase != nectx_pkg::PhIdle);
      r.frame_end = fend;
      expected_line.push_back(r);
    endfunction

    function void compare_result(logic lvl, logic bsy, logic fe);
      nectx_pkg::res_t want;
      if (expected_line.size() == 0) begin
        $error("result with no item waiting: ir_level=%0b busy_res=%0b frame_end=%0b",
               lvl, bsy, fe);
        mismatches++;
        return;
      end
      want = expected_line.pop_front();
      if (lvl !== want.ir_level) begin
        $error("ir_level: expected %0b, got %0b", want.ir_level, lvl);
        mismatches++;
      end
      if (bsy !== want.busy) begin
        $error("busy_res: expected %0b, got %0b", want.busy, bsy);
        mismatches++;
      end
      if (fe !== want.frame_end) begin
        $error("frame_end: expected %0b, got %0b", want.frame_end, fe);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                mode_i = 1'b0;
  logic [ByteW-1:0]    address_i = '0;
  logic [ByteW-1:0]    payload_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                ir_level_o;
  logic                busy_res_o;
  logic                frame_end_o;

  frame_tracker    tracker = new();
  int unsigned     items_sent;
  int unsigned     settings_used;
  int unsigned     tx_calm;
  int unsigned     rdy_hold;
  int unsigned     rdy_sel;
  longint unsigned cycles;

  nec_ir_frame_transmitter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .address_i   (address_i),
    .payload_i   (payload_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ir_level_o  (ir_level_o),
    .busy_res_o  (busy_res_o),
    .frame_end_o (frame_end_o)
  );

  always #10ns clk_i = ~clk_i;

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Result side: random stalls, mostly short, a few long, with long ready stretches
  always @(posedge clk_i) begin
    if (rdy_hold != 0) begin
      rdy_hold--;
    end else begin
      rdy_sel = $urandom_range(0, 99);
      if (rdy_sel < 5) begin
        out_ready_i <= 1'b1;
        rdy_hold = $urandom_range(100, 400);
      end else if (rdy_sel < 75) begin
        out_ready_i <= 1'b1;
        rdy_hold = $urandom_range(0, 3);
      end else if (rdy_sel < 97) begin
        out_ready_i <= 1'b0;
        rdy_hold = $urandom_range(0, 2);
      end else begin
        out_ready_i <= 1'b0;
        rdy_hold = $urandom_range(10, 40);
      end
    end
  end

  // Check every result taken
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.compare_result(ir_level_o, busy_res_o, frame_end_o);
    end
  end

  // Guard against a hung handshake
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Gap before the next item: mostly none, some short, few long, now and then a calm run
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (tx_calm != 0) begin
      tx_calm--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r < 2) begin
      tx_calm = $urandom_range(50, 300);
      return 0;
    end
    if (r < 140) return 0;
    if (r < 194) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic push_item(logic mode, logic [ByteW-1:0] addr, logic [ByteW-1:0] pay);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    address_i <= addr;
    payload_i <= pay;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.log_item(mode, addr, pay);
    items_sent++;
  endtask

  // Ticks until the frame is over; noisy runs throw in requests that must be ignored
  task automatic tick_until_idle(bit noisy);
    while (tracker.busy()) begin
      if (noisy && $urandom_range(0, 31) == 0) begin
        push_item(1'b1, ByteW'($urandom), ByteW'($urandom));
      end else begin
        push_item(1'b0, ByteW'($urandom), ByteW'($urandom));
      end
    end
  endtask

  task automatic run_frame(logic [ByteW-1:0] addr, logic [ByteW-1:0] pay, bit noisy);
    push_item(1'b1, addr, pay);
    tick_until_idle(noisy);
    repeat ($urandom_range(0, 3)) push_item(1'b0, ByteW'($urandom), ByteW'($urandom));
  endtask

  // Let every result drain before touching registers
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.set_reg(idx, data);
  endtask

  task automatic program_timing(logic [CfgDataW-1:0] car, logic [CfgDataW-1:0] hm,
                                logic [CfgDataW-1:0] hs, logic [CfgDataW-1:0] bm,
                                logic [CfgDataW-1:0] zs, logic [CfgDataW-1:0] os,
                                logic [CfgDataW-1:0] st);
    write_reg(nectx_pkg::RegCarrierHalf, car);
    write_reg(nectx_pkg::RegHeaderMark, hm);
    write_reg(nectx_pkg::RegHeaderSpace, hs);
    write_reg(nectx_pkg::RegBitMark, bm);
    write_reg(nectx_pkg::RegZeroSpace, zs);
    write_reg(nectx_pkg::RegOneSpace, os);
    write_reg(nectx_pkg::RegStopLen, st);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Short segments mostly, now and then a zero or a longer one
  function automatic logic [CfgDataW-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 9) return CfgDataW'($urandom_range(5, 40));
    return CfgDataW'($urandom_range(1, 4));
  endfunction

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return ByteW'($urandom);
    endcase
  endfunction

  // Stimulus
  initial begin
    int unsigned rand_start;
    logic [CfgDataW-1:0] car;
    wait (rst_ni);
    @(posedge clk_i);
    settings_used = 1;

    // reset timing: idle tick, a request, a request while busy, carrier at the default
    // half period; then the lengths shrink mid-frame so the frame closes quickly
    push_item(1'b0, 8'hFF, 8'hFF);
    push_item(1'b1, 8'h00, 8'hFF);
    push_item(1'b1, 8'hFF, 8'h00);
    repeat (60) push_item(1'b0, pick_byte(), pick_byte());
    settle();
    program_timing(14'd12, 14'd1, 14'd2, 14'd1, 14'd1, 14'd2, 14'd3);
    tick_until_idle(1'b0);
    push_item(1'b0, 8'h00, 8'h00);
    settle();

    // shortest lengths, carrier toggling every tick, back-to-back frames
    program_timing(14'd1, 14'd1, 14'd1, 14'd1, 14'd1, 14'd1, 14'd1);
    push_item(1'b1, 8'hFF, 8'h00);
    tick_until_idle(1'b0);
    push_item(1'b1, 8'hFF, 8'hFF);
    tick_until_idle(1'b0);
    settle();

    // zero everywhere: lengths behave as one, zero half period toggles each tick
    program_timing(14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0);
    run_frame(8'hA5, 8'h5A, 1'b0);
    settle();

    // longest header, widest carrier; the unused index must change nothing; the header
    // length then drops below the count reached and the rest of the frame runs short
    write_reg(RegUnused, 14'd1);
    program_timing(14'h3FFF, 14'd16383, 14'd16383, 14'd1, 14'd2, 14'd3, 14'd16383);
    push_item(1'b1, 8'h3C, 8'hC3);
    repeat (300) push_item(1'b0, pick_byte(), pick_byte());
    settle();
    program_timing(14'h3FFF, 14'd5, 14'd3, 14'd1, 14'd2, 14'd3, 14'd2);
    tick_until_idle(1'b0);
    settle();

    // random timings and frames
    rand_start = items_sent;
    while (items_sent - rand_start < RandItems) begin
      car = ($urandom_range(0, 5) == 0) ? CfgDataW'($urandom) :
                                          CfgDataW'($urandom_range(0, 5));
      program_timing(car, pick_len(), pick_len(), pick_len(), pick_len(), pick_len(),
                     pick_len());
      repeat ($urandom_range(0, 2)) push_item(1'b0, pick_byte(), pick_byte());
      repeat ($urandom_range(1, 3)) run_frame(pick_byte(), pick_byte(), 1'b1);
      settle();
    end

    settle();
    $display("Drove %0d items over %0d timing settings: %0d frames sent in full,",
             items_sent, settings_used, tracker.frames_done);
    $display("%0d frame requests ignored while a frame was on the line.",
             tracker.ignored_sends);
    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
